@@ rtl/tcpq_pkg.sv @@
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants of the two-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    // default queue depth
    localparam int CAPACITY_DEF = 16;

    // payload widths
    localparam int ID_W  = 16;
    localparam int KEY_W = 8;
    localparam int OCC_W = 5;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_THRESHOLD = '0;
    localparam logic [KEY_W-1:0]  THRESHOLD_RESET = 8'd60;

    // queue commands
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SERVE  = 2'd1,
        OP_CANCEL = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
    } cmd_t;

endpackage

@@ rtl/tcpq_if.sv @@
// ----------------------------------------------------------------------------
// tcpq_if
// Request and response channels of the two-class priority queue.
// ----------------------------------------------------------------------------

// request channel
interface tcpq_req_if import tcpq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       opcode;
    logic [ID_W-1:0]  req_id;
    logic [KEY_W-1:0] req_key;

    modport source (output valid, output opcode, output req_id, output req_key, input ready);
    modport sink   (input valid, input opcode, input req_id, input req_key, output ready);
endinterface

// response channel
interface tcpq_rsp_if import tcpq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             ok;
    logic [ID_W-1:0]  out_id;
    logic [KEY_W-1:0] out_key;
    logic [OCC_W-1:0] occupancy;

    modport source (output valid, output ok, output out_id, output out_key,
                    output occupancy, input ready);
    modport sink   (input valid, input ok, input out_id, input out_key,
                    input occupancy, output ready);
endinterface

@@ rtl/tcpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Command sequencer: capture, lookup, update, and the response valid flag.
// ----------------------------------------------------------------------------
module tcpq_ctrl import tcpq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // response slot is free or drains this cycle
    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (out_free)
                begin
                    state_next = in_valid ? ST_LOOK : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_LOOK:
            begin
                cmd.lookup = 1'b1;
            end
            ST_UPD:
            begin
                cmd.update = out_free;
                in_ready   = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.capture = in_ready && in_valid;
    end

    // response valid flag
    always_comb
    begin
        if (cmd.update)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/tcpq_dp.sv @@
// ----------------------------------------------------------------------------
// tcpq_dp
// Queue datapath: a row of slot cells that compare a broadcast id and shift.
// ----------------------------------------------------------------------------
module tcpq_dp import tcpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cmd_t                              cmd,
    input  logic [KEY_W-1:0]                  threshold,
    input  op_t                               opcode,
    input  logic [ID_W-1:0]                   req_id,
    input  logic [KEY_W-1:0]                  req_key,
    output logic                              ok,
    output logic [ID_W-1:0]                   out_id,
    output logic [KEY_W-1:0]                  out_key,
    output logic [OCC_W-1:0]                  occupancy,
    output logic [$clog2(CAPACITY+1)-1:0]     entry_count,
    output logic [$clog2(CAPACITY+1)-1:0]     prio_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // slot cells
    logic [ID_W-1:0]  slot_id_reg   [CAPACITY];
    logic [ID_W-1:0]  slot_id_next  [CAPACITY];
    logic [KEY_W-1:0] slot_key_reg  [CAPACITY];
    logic [KEY_W-1:0] slot_key_next [CAPACITY];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] pcount_reg;
    logic [CNT_W-1:0] pcount_next;

    // captured request
    op_t              op_reg;
    logic [ID_W-1:0]  id_reg;
    logic [KEY_W-1:0] key_reg;

    // lookup results
    logic             found_reg;
    logic             found_next;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;
    logic [KEY_W-1:0] hit_key_reg;
    logic [KEY_W-1:0] hit_key_next;

    // response payload
    logic             ok_reg;
    logic             ok_next;
    logic [ID_W-1:0]  out_id_reg;
    logic [ID_W-1:0]  out_id_next;
    logic [KEY_W-1:0] out_key_reg;
    logic [KEY_W-1:0] out_key_next;
    logic [OCC_W-1:0] occupancy_reg;

    // update controls
    logic             is_prio;
    logic [CNT_W-1:0] ins_pos;
    logic [CNT_W-1:0] rm_pos;
    logic             do_ins;
    logic             do_rm;

    // capture the request beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            id_reg  <= req_id;
            key_reg <= req_key;
        end
    end

    // broadcast id compare over the live slots; ids are unique so one hit at most
    always_comb
    begin
        found_next   = 1'b0;
        pos_next     = '0;
        hit_key_next = '0;
        for (int q = 0; q < CAPACITY; q++)
        begin
            if ((CNT_W'(q) < count_reg) && (slot_id_reg[q] == id_reg))
            begin
                found_next   = 1'b1;
                pos_next     = pos_next | IDX_W'(q);
                hit_key_next = hit_key_next | slot_key_reg[q];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            found_reg   <= found_next;
            pos_reg     <= pos_next;
            hit_key_reg <= hit_key_next;
        end
    end

    // command decode
    always_comb
    begin
        is_prio      = key_reg >= threshold;
        ins_pos      = is_prio ? pcount_reg : count_reg;
        do_ins       = 1'b0;
        do_rm        = 1'b0;
        rm_pos       = CNT_W'(pos_reg);
        ok_next      = 1'b0;
        out_id_next  = '0;
        out_key_next = '0;
        unique case (op_reg)
            OP_INSERT:
            begin
                do_ins  = (count_reg < CAP_CNT) && !found_reg;
                ok_next = do_ins;
            end
            OP_SERVE:
            begin
                rm_pos  = '0;
                do_rm   = count_reg != '0;
                ok_next = do_rm;
                if (do_rm)
                begin
                    out_id_next = slot_id_reg[0];
                end
            end
            OP_CANCEL:
            begin
                do_rm   = found_reg;
                ok_next = found_reg;
            end
            OP_QUERY:
            begin
                ok_next = found_reg;
                if (found_reg)
                begin
                    out_key_next = hit_key_reg;
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // per-cell shift and load
    always_comb
    begin
        for (int q = 0; q < CAPACITY; q++)
        begin
            slot_id_next[q]  = slot_id_reg[q];
            slot_key_next[q] = slot_key_reg[q];
        end
        count_next  = count_reg;
        pcount_next = pcount_reg;
        if (do_ins)
        begin
            // open a gap at the insert point
            for (int q = 1; q < CAPACITY; q++)
            begin
                if ((CNT_W'(q) > ins_pos) && (CNT_W'(q) <= count_reg))
                begin
                    slot_id_next[q]  = slot_id_reg[q-1];
                    slot_key_next[q] = slot_key_reg[q-1];
                end
            end
            for (int q = 0; q < CAPACITY; q++)
            begin
                if (CNT_W'(q) == ins_pos)
                begin
                    slot_id_next[q]  = id_reg;
                    slot_key_next[q] = key_reg;
                end
            end
            count_next = count_reg + 1'b1;
            if (is_prio)
            begin
                pcount_next = pcount_reg + 1'b1;
            end
        end
        else if (do_rm)
        begin
            // close the gap left by the removed entry
            for (int q = 0; q < CAPACITY - 1; q++)
            begin
                if ((CNT_W'(q) >= rm_pos)
                    && (((CNT_W+1)'(q) + 1'b1) < {1'b0, count_reg}))
                begin
                    slot_id_next[q]  = slot_id_reg[q+1];
                    slot_key_next[q] = slot_key_reg[q+1];
                end
            end
            count_next = count_reg - 1'b1;
            if (rm_pos < pcount_reg)
            begin
                pcount_next = pcount_reg - 1'b1;
            end
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            for (int q = 0; q < CAPACITY; q++)
            begin
                slot_id_reg[q]  <= slot_id_next[q];
                slot_key_reg[q] <= slot_key_next[q];
            end
        end
    end

    // counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            pcount_reg <= '0;
        end
        else if (cmd.update)
        begin
            count_reg  <= count_next;
            pcount_reg <= pcount_next;
        end
    end

    // response register
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            ok_reg        <= ok_next;
            out_id_reg    <= out_id_next;
            out_key_reg   <= out_key_next;
            occupancy_reg <= OCC_W'(count_next);
        end
    end

    assign ok          = ok_reg;
    assign out_id      = out_id_reg;
    assign out_key     = out_key_reg;
    assign occupancy   = occupancy_reg;
    assign entry_count = count_reg;
    assign prio_count  = pcount_reg;

endmodule

@@ rtl/two_class_priority_queue.sv @@
// ----------------------------------------------------------------------------
// two_class_priority_queue
// Ordered queue with a priority class ahead of a normal class, both FIFO.
// ----------------------------------------------------------------------------
// Each command (insert, serve, cancel, query) passes through a lookup
// cycle in which every live slot compares its id against the request id,
// and an update cycle in which the slot cells shift and the response
// register is loaded. The next command is accepted in the update cycle,
// so it overlaps the previous update while the response side keeps up;
// a stalled response holds the update cycle until the register frees.
// Slot contents need no clearing after reset, only the counts reset. The
// threshold register (byte address 0) only affects later inserts.
module two_class_priority_queue import tcpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    tcpq_req_if.sink          req,
    tcpq_rsp_if.source        rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [KEY_W-1:0] threshold_reg;
    logic [KEY_W-1:0] threshold_next;
    logic             thr_sel;
    cmd_t             cmd;
    logic [CNT_W-1:0] entry_count;
    logic [CNT_W-1:0] prio_count;

    // register access
    assign pready  = 1'b1;
    assign thr_sel = paddr[ADDR_W-1:2] == REG_THRESHOLD;
    assign prdata  = thr_sel ? DATA_W'(threshold_reg) : '0;

    always_comb
    begin
        threshold_next = threshold_reg;
        if (psel && penable && pwrite && pready && thr_sel)
        begin
            threshold_next = pwdata[KEY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    // sequencer
    tcpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // slot cells and response register
    tcpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .threshold   (threshold_reg),
        .opcode      (op_t'(req.opcode)),
        .req_id      (req.req_id),
        .req_key     (req.req_key),
        .ok          (rsp.ok),
        .out_id      (rsp.out_id),
        .out_key     (rsp.out_key),
        .occupancy   (rsp.occupancy),
        .entry_count (entry_count),
        .prio_count  (prio_count)
    );

`ifndef NO_ASSERTIONS
    // class boundary never passes the tail
    a_prio_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        prio_count <= entry_count)
        else $error("priority count exceeds entry count");

    // queue never overfills
    a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // update only loads a free response register
    a_update_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (!rsp.valid || rsp.ready))
        else $error("response overwritten before it was taken");

    // an accepted beat is in lookup on the next cycle, so no beat is taken then
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (cmd.lookup && !req.ready))
        else $error("request accepted during lookup");
`endif

endmodule
